>>> src/length_prefixed_nal_to_start_code_macros.svh
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_code_macros.svh
// Assertion macros used by the NAL conversion parser.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_NAL_TO_START_CODE_MACROS_SVH
`define LENGTH_PREFIXED_NAL_TO_START_CODE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define LPNC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included.
`define LPNC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> src/lpnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpnc_pkg
// Types and constants for the length-prefixed to start-code NAL converter.
// ----------------------------------------------------------------------------
package lpnc_pkg;

  // Packet status reported with the closing beat
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TRUNC_LEN   = 2'd1,
    STATUS_NAL_OVERRUN = 2'd2,
    STATUS_FORBIDDEN   = 2'd3
  } status_e;

  localparam int unsigned MaxResults  = 4;
  localparam int unsigned ForbiddenBit = 7;

  localparam logic [7:0] StartCode [MaxResults] = '{8'h00, 8'h00, 8'h00, 8'h01};

  // One result beat
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       packet_end;
    status_e    status;
  } result_t;

  // Results produced by one input byte, lowest index first
  typedef struct packed {
    logic [2:0]                    num;
    result_t [MaxResults-1:0]      item;
  } push_t;

endpackage

>>> src/length_prefixed_nal_to_start_code.sv
// A byte's results pass the input register and then the result queue before the output.
// Throughput: one byte in and one beat out per cycle unless stalled; the single read port
//   of the queue sets the output rate, and a finished length field adds a burst of four.
// Input ready drops only when the queue lacks room for the held byte's results.
// Reset (rst_ni low, asynchronous): parser state cleared, queue emptied.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_nal_to_start_code
// Converts length-prefixed NAL units of one packet into start-code framing.
// ----------------------------------------------------------------------------
module length_prefixed_nal_to_start_code #(
  parameter int unsigned QueueDepth = 8  // power of two, at least 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats: one payload byte each
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  // output beats: start code bytes, NAL bytes and packet status
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       packet_end_o,
  output logic [1:0] status_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  lpnc_pkg::push_t   push;
  lpnc_pkg::result_t head;
  logic [CntW-1:0]   free;

  // Parser: registers the byte, drops length fields, swaps in the start code,
  // checks the forbidden bit and tracks the packet status.
  lpnc_parser #(
    .CntW (CntW)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .free_i      (free),
    .push_o      (push)
  );

  // Queue: absorbs the four-beat start code burst and parts the two handshakes.
  lpnc_result_queue #(
    .Depth (QueueDepth),
    .CntW  (CntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign byte_valid_o = head.byte_valid;
  assign out_byte_o   = head.out_byte;
  assign run_last_o   = head.run_last;
  assign packet_end_o = head.packet_end;
  assign status_o     = head.status;

endmodule

>>> src/lpnc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpnc_parser
// Input register and packet parser: strips length fields, builds result beats.
// ----------------------------------------------------------------------------
`include "length_prefixed_nal_to_start_code_macros.svh"

module lpnc_parser #(
  parameter int unsigned CntW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [CntW-1:0]  free_i,
  output lpnc_pkg::push_t  push_o
);

  logic        stage_vld_q, stage_vld_d;
  logic [7:0]  stage_data_q;
  logic        stage_last_q;

  logic        in_payload_q, in_payload_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] left_q, left_d;
  logic        at_start_q, at_start_d;
  lpnc_pkg::status_e err_q, err_d;

  logic [1:0]  len_cnt_inc;
  logic [31:0] len_acc_shift;
  logic [31:0] left_dec;
  logic [2:0]  num;
  lpnc_pkg::result_t [lpnc_pkg::MaxResults-1:0] item;
  logic        advance;

  assign len_cnt_inc   = len_cnt_q + 2'd1;
  assign len_acc_shift = {len_acc_q[23:0], stage_data_q};
  assign left_dec      = left_q - 32'd1;

  // Result count and beats for the held byte
  always_comb begin
    num  = 3'd0;
    item = '0;
    if (err_q != lpnc_pkg::STATUS_OK) begin
      if (stage_last_q) begin
        num     = 3'd1;
        item[0] = '{1'b0, 8'h00, 1'b1, 1'b1, err_q};
      end
    end else if (!in_payload_q) begin
      if (len_cnt_inc != 2'd0) begin
        if (stage_last_q) begin
          num     = 3'd1;
          item[0] = '{1'b0, 8'h00, 1'b1, 1'b1, lpnc_pkg::STATUS_TRUNC_LEN};
        end
      end else begin
        num = 3'd4;
        for (int i = 0; i < lpnc_pkg::MaxResults - 1; i++) begin
          item[i] = '{1'b1, lpnc_pkg::StartCode[i], 1'b0, 1'b0, lpnc_pkg::STATUS_OK};
        end
        item[3] = '{1'b1, lpnc_pkg::StartCode[3], 1'b1, stage_last_q,
                    (stage_last_q && len_acc_shift != 32'd0) ?
                    lpnc_pkg::STATUS_NAL_OVERRUN : lpnc_pkg::STATUS_OK};
      end
    end else if (at_start_q && stage_data_q[lpnc_pkg::ForbiddenBit]) begin
      if (stage_last_q) begin
        num     = 3'd1;
        item[0] = '{1'b0, 8'h00, 1'b1, 1'b1, lpnc_pkg::STATUS_FORBIDDEN};
      end
    end else begin
      num     = 3'd1;
      item[0] = '{1'b1, stage_data_q, 1'b1, stage_last_q,
                  (stage_last_q && left_dec != 32'd0) ?
                  lpnc_pkg::STATUS_NAL_OVERRUN : lpnc_pkg::STATUS_OK};
    end
  end

  assign advance     = stage_vld_q && (CntW'(num) <= free_i);
  assign in_ready_o  = !stage_vld_q || advance;
  assign stage_vld_d = in_valid_i ? 1'b1 : (stage_vld_q && !advance);

  assign push_o.num  = advance ? num : 3'd0;
  assign push_o.item = item;

  // Parser state update for an advancing byte
  always_comb begin
    in_payload_d = in_payload_q;
    len_cnt_d    = len_cnt_q;
    len_acc_d    = len_acc_q;
    left_d       = left_q;
    at_start_d   = at_start_q;
    err_d        = err_q;
    if (advance) begin
      if (stage_last_q) begin
        in_payload_d = 1'b0;
        len_cnt_d    = 2'd0;
        len_acc_d    = '0;
        left_d       = '0;
        at_start_d   = 1'b0;
        err_d        = lpnc_pkg::STATUS_OK;
      end else if (err_q != lpnc_pkg::STATUS_OK) begin
        // drop bytes until the packet ends
      end else if (!in_payload_q) begin
        len_cnt_d = len_cnt_inc;
        if (len_cnt_inc != 2'd0) begin
          len_acc_d = len_acc_shift;
        end else begin
          left_d    = len_acc_shift;
          len_acc_d = '0;
          if (len_acc_shift != 32'd0) begin
            in_payload_d = 1'b1;
            at_start_d   = 1'b1;
          end
        end
      end else if (at_start_q && stage_data_q[lpnc_pkg::ForbiddenBit]) begin
        err_d = lpnc_pkg::STATUS_FORBIDDEN;
      end else begin
        at_start_d = 1'b0;
        left_d     = left_dec;
        if (left_dec == 32'd0) begin
          in_payload_d = 1'b0;
          len_cnt_d    = 2'd0;
          len_acc_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q  <= 1'b0;
      in_payload_q <= 1'b0;
      len_cnt_q    <= 2'd0;
      len_acc_q    <= '0;
      left_q       <= '0;
      at_start_q   <= 1'b0;
      err_q        <= lpnc_pkg::STATUS_OK;
    end else begin
      stage_vld_q  <= stage_vld_d;
      in_payload_q <= in_payload_d;
      len_cnt_q    <= len_cnt_d;
      len_acc_q    <= len_acc_d;
      left_q       <= left_d;
      at_start_q   <= at_start_d;
      err_q        <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_data_q <= data_byte_i;
      stage_last_q <= last_byte_i;
    end
  end

  `LPNC_ASSERT(a_start_in_payload, clk_i, rst_ni, at_start_q |-> in_payload_q, "NAL start flag outside payload")
  `LPNC_ASSERT(a_payload_left, clk_i, rst_ni, in_payload_q |-> (left_q != 32'd0), "payload with no bytes left")
  `LPNC_ASSERT(a_len_not_payload, clk_i, rst_ni, (len_cnt_q != 2'd0) |-> !in_payload_q, "partial length field inside payload")
  `LPNC_ASSERT(a_last_clears, clk_i, rst_ni, (advance && stage_last_q) |=> (!in_payload_q && err_q == lpnc_pkg::STATUS_OK), "packet end did not clear state")

endmodule

>>> src/lpnc_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpnc_result_queue
// Result FIFO: takes up to four beats per cycle, hands out one per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module lpnc_result_queue #(
  parameter int unsigned Depth = 8,
  parameter int unsigned CntW  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpnc_pkg::push_t   push_i,
  output logic [CntW-1:0]   free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lpnc_pkg::result_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  lpnc_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign free_o      = CntW'(Depth) - count_q;

  assign wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
  assign rd_ptr_d = rd_ptr_q + PtrW'(pop);
  assign count_d  = count_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write each pushed beat at its own slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < lpnc_pkg::MaxResults; i++) begin
      if (3'(i) < push_i.num) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= push_i.item[i];
      end
    end
  end

endmodule
